/* design/bounded_int_list_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Bounded integer list engine: assertion macros
// Shared macros for the concurrent checks of the list engine.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INT_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_INT_LIST_ENGINE_TOP_DEFINES_SVH

// Checked on every rising edge of clock while reset is low.
`define BILE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define BILE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/bile_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded integer list engine: package
// Field widths, stream packing and command codes of the list engine.
// ----------------------------------------------------------------------------
package bile_pkg;

   localparam int WORD_W     = 32;
   localparam int POS_W      = 4;
   localparam int CMD_W      = 2;
   localparam int FPOS_W     = 5;
   localparam int CNT_W      = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [FPOS_W-1:0] fpos_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_FIND   = 2'd2;
   localparam cmd_type CMD_NTH    = 2'd3;

endpackage

/* design/bile_ram.sv */
// ----------------------------------------------------------------------------
// Bounded integer list engine: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* design/bounded_int_list_engine_top.sv */
// ----------------------------------------------------------------------------
// Bounded integer list engine
// An ordered list of up to DEPTH signed 32-bit integers, head at position 0,
// with insert at head, remove first match, find and read nth commands.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  -------  ---------  ------------------------------------------------------
//  req_     in         tuser: command; tdata: operand value, position index
//  rsp_     out        tdata: success, position, value, count, empty flag
//
// A transaction ends at once when there is nothing to walk (insert on a full
// or empty list, nth out of range); an nth read reads one entry, and a walk
// goes one entry a cycle through the RAM read port; the next request is taken
// as the result appears.
// Reset clears the count and the sequencer only; the entry RAM needs no pass.
// A finished transaction waits in its last state while the output is occupied.
//
`include "bounded_int_list_engine_top_defines.svh"

module bounded_int_list_engine_top
   import bile_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] operand_value, [35:32] position_index, [39:36] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [CMD_W-1:0]      req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] success, [5:1] found_position, [37:6] read_value,
   // [42:38] element_count, [43] is_empty, [47:44] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Address width of the entry RAM, and a count width that can hold DEPTH.
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0; // waiting for a request
   localparam logic [2:0] ST_UP   = 3'd1; // insert: shift entries toward tail
   localparam logic [2:0] ST_SCAN = 3'd2; // find or remove: search from head
   localparam logic [2:0] ST_DOWN = 3'd3; // remove: close the gap
   localparam logic [2:0] ST_NTH  = 3'd4; // read one entry
   localparam logic [2:0] ST_DONE = 3'd5; // hand the result to the output

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // next RAM address to read
   logic          more_ff, more_in;   // reads still to issue
   logic          pend_ff, pend_in;   // a read is in flight
   logic          rsp_valid_ff, rsp_valid_in;

   // Captured request and the read in flight.
   cmd_type       cmd_ff, cmd_in;
   word_type      val_ff, val_in;
   pos_type       pos_ff, pos_in;
   logic [AW-1:0] tag_ff, tag_in;     // address of the read in flight

   // Result being built, then the output register.
   logic          st_ok_ff, st_ok_in;
   fpos_type      st_fpos_ff, st_fpos_in;
   word_type      st_rval_ff, st_rval_in;
   logic          out_ok_ff, out_ok_in;
   fpos_type      out_fpos_ff, out_fpos_in;
   word_type      out_rval_ff, out_rval_in;
   cnt_type       out_count_ff, out_count_in;
   logic          out_empty_ff, out_empty_in;

   // Entry RAM port.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   word_type      ram_wdata;
   logic [AW-1:0] ram_raddr;
   word_type      ram_rdata;

   // Request fields.
   cmd_type  req_command;
   word_type req_operand;
   pos_type  req_position;

   assign req_command  = req_tuser;
   assign req_operand  = req_tdata[WORD_W-1:0];
   assign req_position = req_tdata[WORD_W+POS_W-1:WORD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_empty_ff, out_count_ff, out_rval_ff,
                        out_fpos_ff, out_ok_ff};

   bile_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The sequencer. Every walk keeps one read in flight: the address is
   // issued in one cycle and its data is used, compared or written back
   // one place further along, in the next.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      more_in      = more_ff;
      pend_in      = 1'b0;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      tag_in       = tag_ff;
      st_ok_in     = st_ok_ff;
      st_fpos_in   = st_fpos_ff;
      st_rval_in   = st_rval_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      out_ok_in    = out_ok_ff;
      out_fpos_in  = out_fpos_ff;
      out_rval_in  = out_rval_ff;
      out_count_in = out_count_ff;
      out_empty_in = out_empty_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = val_ff;
      ram_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_command;
               val_in     = req_operand;
               pos_in     = req_position;
               st_ok_in   = 1'b0;
               st_fpos_in = '0;
               st_rval_in = '0;
               case (req_command)
                  CMD_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        state_in = ST_DONE;
                     end else if (count_ff == '0) begin
                        // Nothing to move: the value becomes the only entry.
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = req_operand;
                        count_in  = CW'(1);
                        st_ok_in  = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        idx_in   = count_ff - CW'(1);
                        more_in  = 1'b1;
                        state_in = ST_UP;
                     end
                  end
                  CMD_REMOVE, CMD_FIND: begin
                     idx_in   = '0;
                     more_in  = (count_ff != '0);
                     state_in = ST_SCAN;
                  end
                  CMD_NTH: begin
                     if (CMPW'(req_position) < CMPW'(count_ff)) begin
                        state_in = ST_NTH;
                     end else begin
                        st_rval_in = '1;
                        state_in   = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_UP: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = tag_ff + AW'(1);
               ram_wdata = ram_rdata;
            end
            if (more_ff) begin
               pend_in = 1'b1;
               tag_in  = idx_ff[AW-1:0];
               if (idx_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  idx_in = idx_ff - CW'(1);
               end
            end else if (!pend_ff) begin
               // All entries have moved up; the head is free.
               ram_we    = 1'b1;
               ram_waddr = '0;
               ram_wdata = val_ff;
               count_in  = count_ff + CW'(1);
               st_ok_in  = 1'b1;
               state_in  = ST_DONE;
            end
         end

         ST_SCAN: begin
            if (pend_ff && (ram_rdata == val_ff)) begin
               if (cmd_ff == CMD_FIND) begin
                  st_ok_in   = 1'b1;
                  st_fpos_in = FPOS_W'(tag_ff);
                  state_in   = ST_DONE;
               end else begin
                  // The walk restarts at the entry after the match to close the gap.
                  idx_in   = CW'(tag_ff) + CW'(1);
                  more_in  = (CW'(tag_ff) + CW'(1)) < count_ff;
                  state_in = ST_DOWN;
               end
            end else if (!more_ff) begin
               if (cmd_ff == CMD_FIND) begin
                  st_fpos_in = '1;
               end
               state_in = ST_DONE;
            end else begin
               pend_in = 1'b1;
               tag_in  = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
               more_in = (idx_ff + CW'(1)) < count_ff;
            end
         end

         ST_DOWN: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = tag_ff - AW'(1);
               ram_wdata = ram_rdata;
            end
            if (more_ff) begin
               pend_in = 1'b1;
               tag_in  = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
               more_in = (idx_ff + CW'(1)) < count_ff;
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
               st_ok_in = 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_NTH: begin
            ram_raddr = AW'(pos_ff);
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               st_ok_in   = 1'b1;
               st_rval_in = ram_rdata;
               state_in   = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_ok_in    = st_ok_ff;
               out_fpos_in  = st_fpos_ff;
               out_rval_in  = st_rval_ff;
               out_count_in = CNT_W'(count_ff);
               out_empty_in = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      tag_ff       <= tag_in;
      st_ok_ff     <= st_ok_in;
      st_fpos_ff   <= st_fpos_in;
      st_rval_ff   <= st_rval_in;
      out_ok_ff    <= out_ok_in;
      out_fpos_ff  <= out_fpos_in;
      out_rval_ff  <= out_rval_in;
      out_count_ff <= out_count_in;
      out_empty_ff <= out_empty_in;
   end

   // The count never passes the capacity.
   `BILE_ASSERT(a_count_bounded, (count_ff <= FULL_COUNT),
      "list count exceeds capacity")

   // Each transaction changes the count by at most one entry.
   `BILE_ASSERT(a_count_step,
      (!$past(reset) && !$stable(count_ff)) |->
         ((count_ff == $past(count_ff) + CW'(1)) ||
          (count_ff == $past(count_ff) - CW'(1))),
      "list count moved by more than one")

   // Entries are written only by an insert or while closing a gap.
   `BILE_ASSERT(a_write_states,
      ram_we |-> ((state_ff == ST_IDLE) || (state_ff == ST_UP) ||
                  (state_ff == ST_DOWN)),
      "entry write outside insert or remove")

   // A finished transaction holds while the output register is occupied.
   `BILE_ASSERT(a_done_holds,
      ((state_ff == ST_DONE) && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE),
      "result overwrote a pending response")

endmodule

/* test/bounded_int_list_engine_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer list engine: stream testbench
// Drives insert, remove, find and read-nth transactions into the list engine.
// A shadow list predicts every response, and a small scoreboard compares each
// response field by field. Both sides of the stream idle at random, and the
// receiver holds off once for a long stretch so that the engine backs up.
// ----------------------------------------------------------------------------
module bounded_int_list_engine_top_test;
   import bile_pkg::*;

   // Size of the list in the engine and in the shadow copy.
   localparam int LIST_DEPTH     = 16;
   // Number of random transactions after the directed opening.
   localparam int RANDOM_ITEMS   = 1600;
   // Accepted transaction after which the receiver makes its long hold-off.
   localparam int HOLD_AT        = 700;
   localparam int HOLD_CYCLES    = 400;
   // Settling time after the last response, scaled from LIST_DEPTH.
   localparam int DRAIN_CYCLES   = 4 * (LIST_DEPTH + 5);
   // Size of the pool of values that are reused to make hits likely.
   localparam int POOL_SIZE      = 8;
   localparam word_type WORD_MIN = word_type'(32'h8000_0000);
   localparam word_type WORD_MAX = word_type'(32'h7FFF_FFFF);
   localparam word_type MINUS_ONE = word_type'(-1);

   // One predicted response, in the order of the fields in rsp_tdata.
   typedef struct {
      logic     success;
      fpos_type found_position;
      word_type read_value;
      cnt_type  element_count;
      logic     is_empty;
   } list_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of the list, works out the response to
   // each accepted request and queues it; each response from the engine is
   // then compared with the oldest queued prediction.
   // -------------------------------------------------------------------------
   class list_scoreboard;
      word_type        shadow_entries [LIST_DEPTH];
      int unsigned     shadow_count;
      list_result_type expected_responses [$];
      int              errors;
      int              cmd_total [4];
      int              cmd_success [4];
      int              full_refusals;
      int              peak_count;

      // First position from the head that holds the value, or -1.
      function int locate(word_type value);
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i] == value) begin
               return i;
            end
         end
         return -1;
      endfunction

      function void note_request(cmd_type cmd, word_type value, pos_type position);
         list_result_type r;
         int              hit;
         r.success        = 1'b0;
         r.found_position = '0;
         r.read_value     = '0;
         case (cmd)
            CMD_INSERT: begin
               if (shadow_count < LIST_DEPTH) begin
                  for (int i = shadow_count; i > 0; i--) begin
                     shadow_entries[i] = shadow_entries[i-1];
                  end
                  shadow_entries[0] = value;
                  shadow_count++;
                  r.success = 1'b1;
               end else begin
                  full_refusals++;
               end
            end
            CMD_REMOVE: begin
               hit = locate(value);
               if (hit >= 0) begin
                  // Close the gap left by the first match.
                  for (int i = hit; i + 1 < shadow_count; i++) begin
                     shadow_entries[i] = shadow_entries[i+1];
                  end
                  shadow_count--;
                  r.success = 1'b1;
               end
            end
            CMD_FIND: begin
               hit = locate(value);
               r.success        = (hit >= 0);
               r.found_position = fpos_type'(hit);
            end
            default: begin
               if (position < shadow_count) begin
                  r.success    = 1'b1;
                  r.read_value = shadow_entries[position];
               end else begin
                  r.read_value = MINUS_ONE;
               end
            end
         endcase
         r.element_count = cnt_type'(shadow_count);
         r.is_empty      = (shadow_count == 0);
         cmd_total[cmd]++;
         if (r.success) begin
            cmd_success[cmd]++;
         end
         if (shadow_count > peak_count) begin
            peak_count = shadow_count;
         end
         expected_responses.push_back(r);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         list_result_type e;
         list_result_type a;
         a.success        = data[0];
         a.found_position = fpos_type'(data[5:1]);
         a.read_value     = word_type'(data[37:6]);
         a.element_count  = cnt_type'(data[42:38]);
         a.is_empty       = data[43];
         if (expected_responses.size() == 0) begin
            $error("Response with no request outstanding: tdata %h", data);
            errors++;
            return;
         end
         e = expected_responses.pop_front();
         if (a.success !== e.success) begin
            $error("success: expected %0d, got %0d", e.success, a.success);
            errors++;
         end
         if (a.found_position !== e.found_position) begin
            $error("found_position: expected %0d, got %0d", e.found_position,
                   a.found_position);
            errors++;
         end
         if (a.read_value !== e.read_value) begin
            $error("read_value: expected %0d, got %0d", e.read_value, a.read_value);
            errors++;
         end
         if (a.element_count !== e.element_count) begin
            $error("element_count: expected %0d, got %0d", e.element_count,
                   a.element_count);
            errors++;
         end
         if (a.is_empty !== e.is_empty) begin
            $error("is_empty: expected %0d, got %0d", e.is_empty, a.is_empty);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the signals of the engine. Every input starts at a
   // known value; they all change on the falling edge from then on.
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   list_scoreboard scoreboard = new();
   // Raised by the sender once HOLD_AT transactions are in, taken by the
   // receiver process, which then counts out its hold-off itself.
   bit             hold_off_request = 1'b0;
   int             requests_sent = 0;
   word_type       value_pool [POOL_SIZE];

   bounded_int_list_engine_top #(
      .DEPTH (LIST_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // -------------------------------------------------------------------------
   // Sender. Idles for the given number of cycles, then offers one
   // transaction from the falling edge and holds it until a rising edge sees
   // the handshake. Valid is left high afterwards, so that a transaction with
   // no gap is offered with no idle cycle in between.
   // -------------------------------------------------------------------------
   task automatic send_command(input cmd_type cmd, input word_type value,
                               input pos_type position, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      // tdata: operand value in the low word, position index above it.
      req_tdata  <= {4'b0000, position, value};
      do begin
         @(posedge clock);
      end while (!req_tready);
      scoreboard.note_request(cmd, value, position);
      requests_sent++;
      if (requests_sent == HOLD_AT) begin
         hold_off_request = 1'b1;
      end
   endtask

   // Mostly short gaps, now and then a long one; a burst mode runs without any.
   function automatic int pick_gap(bit back_to_back);
      int roll;
      roll = $urandom_range(0, 99);
      if (back_to_back || roll < 75) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Values are drawn mostly from a small pool, so that removes and finds hit
   // entries that are really in the list; the rest are fully random words.
   function automatic word_type pick_value();
      if ($urandom_range(0, 99) < 30) begin
         return word_type'($urandom);
      end
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // -------------------------------------------------------------------------
   // Receiver. Ready comes in bursts: short runs of stalls and of acceptance,
   // now and then a long stall, and now and then a long stretch with no stall
   // at all. Once, on request, it holds ready low over a stretch set by
   // HOLD_CYCLES while the sender keeps offering, so the output register fills
   // and the engine has to stall its input.
   // -------------------------------------------------------------------------
   initial begin
      int burst;
      int roll;
      bit level;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               level = 1'b1;
               burst = $urandom_range(100, 300);
            end else if (roll < 60) begin
               level = 1'b1;
               burst = $urandom_range(1, 12);
            end else if (roll < 95) begin
               level = 1'b0;
               burst = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               burst = $urandom_range(20, 60);
            end
            rsp_tready <= level;
            repeat (burst - 1) @(negedge clock);
         end
      end
   end

   // Every response transaction is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_response(rsp_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, a directed opening, then random episodes.
   // -------------------------------------------------------------------------
   initial begin
      int      episode_length;
      int      episode_kind;
      int      roll;
      bit      back_to_back;
      cmd_type cmd;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening. The list starts empty, so every command that needs
      // an entry must fail first.
      send_command(CMD_REMOVE, 32'sd5, 4'd0, 0);
      send_command(CMD_FIND, 32'sd5, 4'd0, 0);
      send_command(CMD_NTH, 32'sd0, 4'd0, 2);
      // Fill with the extremes of the value range; the list becomes
      // 0, -1, max, min from the head.
      send_command(CMD_INSERT, WORD_MIN, 4'd0, 0);
      send_command(CMD_INSERT, WORD_MAX, 4'd0, 0);
      send_command(CMD_INSERT, MINUS_ONE, 4'd0, 1);
      send_command(CMD_INSERT, 32'sd0, 4'd0, 0);
      send_command(CMD_FIND, WORD_MIN, 4'd15, 0);
      send_command(CMD_FIND, 32'sd12345, 4'd0, 0);
      // A stored -1 at a valid position must still report success.
      send_command(CMD_NTH, 32'sd0, 4'd1, 0);
      send_command(CMD_NTH, 32'sd0, 4'd3, 0);
      send_command(CMD_NTH, 32'sd0, 4'd4, 0);
      send_command(CMD_NTH, WORD_MAX, 4'd15, 3);
      // A duplicate at the head: remove and find both take the first match.
      send_command(CMD_INSERT, MINUS_ONE, 4'd0, 0);
      send_command(CMD_REMOVE, MINUS_ONE, 4'd0, 0);
      send_command(CMD_FIND, MINUS_ONE, 4'd0, 0);
      send_command(CMD_REMOVE, 32'sd777, 4'd0, 0);
      // Remove from the tail, then the head, then the tail again, until empty.
      send_command(CMD_REMOVE, WORD_MIN, 4'd0, 0);
      send_command(CMD_REMOVE, 32'sd0, 4'd0, 0);
      send_command(CMD_REMOVE, WORD_MAX, 4'd0, 0);
      send_command(CMD_REMOVE, MINUS_ONE, 4'd0, 0);
      send_command(CMD_NTH, 32'sd0, 4'd0, 0);

      // Random episodes. A fill episode mostly inserts and drives the list to
      // full and past it; a drain episode mostly removes pool values until
      // empty; a mixed one spreads evenly over the four commands.
      value_pool[0] = WORD_MIN;
      value_pool[1] = WORD_MAX;
      value_pool[2] = MINUS_ONE;
      value_pool[3] = '0;
      while (requests_sent < RANDOM_ITEMS + 22) begin
         for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = word_type'($urandom);
         end
         episode_kind   = $urandom_range(0, 2);
         episode_length = $urandom_range(10, 50);
         back_to_back   = ($urandom_range(0, 99) < 30);
         repeat (episode_length) begin
            roll = $urandom_range(0, 99);
            case (episode_kind)
               0: cmd = (roll < 75) ? CMD_INSERT : cmd_type'($urandom_range(1, 3));
               1: cmd = (roll < 10) ? CMD_INSERT :
                        (roll < 70) ? CMD_REMOVE :
                        (roll < 85) ? CMD_FIND : CMD_NTH;
               default: cmd = cmd_type'($urandom_range(0, 3));
            endcase
            send_command(cmd, pick_value(), pos_type'($urandom_range(0, 15)),
                         pick_gap(back_to_back));
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Wait for every predicted response, then long enough for a stray one
      // to show up; the watchdog below catches a response that never comes.
      while (scoreboard.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"Covered %0d transactions: %0d inserts (%0d refused on a full list), ",
                "%0d removes (%0d hits),"},
               requests_sent, scoreboard.cmd_total[CMD_INSERT], scoreboard.full_refusals,
               scoreboard.cmd_total[CMD_REMOVE], scoreboard.cmd_success[CMD_REMOVE]);
      $display("%0d finds (%0d hits), %0d nth reads (%0d in range); list peaked at %0d entries.",
               scoreboard.cmd_total[CMD_FIND], scoreboard.cmd_success[CMD_FIND],
               scoreboard.cmd_total[CMD_NTH], scoreboard.cmd_success[CMD_NTH],
               scoreboard.peak_count);
      if (scoreboard.errors == 0) begin
         $display("PASS bounded_int_list_engine_top");
      end else begin
         $display("FAIL bounded_int_list_engine_top");
      end
      $finish;
   end

   // Watchdog: the slowest correct run needs far less than this.
   initial begin
      #10_000_000;
      $display("FAIL bounded_int_list_engine_top");
      $finish;
   end

endmodule
